### rtl/core/gdad_pkg.sv
// Shared types, constants and calendar helpers for the Gregorian date shifter.
// Used by gregorian_date_add_days; no dependencies of its own.
`default_nettype none

package gdad_pkg;

    // width of the signed day offset
    localparam int GDAD_DELTA_BITS = 16;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int MLEN_W  = 5;

    localparam int YEAR_MAX = 9999;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MONTH = 2'd1,
        ST_BAD_YEAR  = 2'd2
    } t_status;

    typedef struct packed {
        logic [YEAR_W-1:0]                 start_year;
        logic [MONTH_W-1:0]                start_month;
        logic [DAY_W-1:0]                  start_day;
        logic [WDAY_W-1:0]                 start_weekday;
        logic signed [GDAD_DELTA_BITS-1:0] day_delta;
    } t_in;

    typedef struct packed {
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
        logic [WDAY_W-1:0]  end_weekday;
        t_status            status;
    } t_out;

    // days in a month; month assumed 1..12
    function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [MLEN_W-1:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // leap from the year taken modulo 400
    function automatic logic leap_of(input logic [8:0] y400);
        return (y400[1:0] == 2'd0) && (y400 != 9'd100) && (y400 != 9'd200)
               && (y400 != 9'd300);
    endfunction

endpackage

`default_nettype wire

### rtl/core/gregorian_date_add_days.sv
// Gregorian date shift by a signed day count, walked one month per cycle.
// An accepted item passes through residue setup (S_FOLD: octal digit sum of the offset and
// year quotient; S_RESID: offset mod 7, year mod 400), the month walk (S_WALK, until it
// sees the walk end) and the load of the output register (S_DONE). Zero offset or bad month
// skip straight to the load. One item in flight: no new item is taken until the output is
// loaded (the walk crosses about 1100 months for a full 16-bit offset), longer while stalled.
// Reset (synchronous, active low) empties the sequencer and the output register.
`default_nettype none

module gregorian_date_add_days (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire gdad_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output gdad_pkg::t_out      o_out_data
);
    import gdad_pkg::*;

    localparam int DB         = GDAD_DELTA_BITS;
    localparam int DW         = DB + 2;
    localparam int YW         = YEAR_W + 1;
    // octal digits of the offset; 8 = 1 mod 7, so their sum keeps the residue
    localparam int DIG_N      = (DB + 2) / 3;
    localparam int XE_W       = 3 * DIG_N;
    localparam int OSUM_W     = 7;
    // floor(y / 400) as (y * Y400_RECIP) >> Y400_SHIFT, exact for any 14-bit year
    localparam int YEAR_CYCLE = 400;
    localparam int Y400_RECIP = 5243;
    localparam int Y400_SHIFT = 21;
    localparam int YQ_W       = 6;
    localparam int YPROD_W    = YEAR_W + 13;
    // 2**DB mod 7, for the sign correction of the offset residue
    localparam int P2M7      = ((DB % 3) == 0) ? 1 : (((DB % 3) == 1) ? 2 : 4);
    localparam logic [3:0] SIGN_ADJ = 4'(7 - P2M7);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FOLD  = 5'b00010,
        S_RESID = 5'b00100,
        S_WALK  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    t_in                   r_in, n_in;
    t_status               r_status, n_status;
    logic                  r_neg, n_neg;
    logic [OSUM_W-1:0]     r_osum, n_osum;
    logic [YQ_W-1:0]       r_yq, n_yq;
    logic [2:0]            r_drem, n_drem;
    logic [8:0]            r_y400, n_y400;
    logic signed [YW-1:0]  r_year, n_year;
    logic [MONTH_W-1:0]    r_month, n_month;
    logic signed [DW-1:0]  r_day, n_day;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;

    // walk datapath
    logic [MONTH_W-1:0]    w_month_step;
    logic signed [YW-1:0]  w_year_step;
    logic [8:0]            w_y400_step;
    logic [MONTH_W-1:0]    w_len_month;
    logic [8:0]            w_len_y400;
    logic [MLEN_W-1:0]     w_len;
    logic signed [DW-1:0]  w_len_s;
    logic signed [DW-1:0]  w_day_sum;
    logic                  w_go;
    // residue datapath
    logic [OSUM_W-1:0]     w_osum;
    logic [YPROD_W-1:0]    w_yprod;
    logic [3:0]            w_osum2, w_osum3;
    logic [2:0]            w_dmod;
    logic [YEAR_W-1:0]     w_yq400, w_ymod;
    // result
    logic [2:0]            w_wd0;
    logic [3:0]            w_radj, w_wsum;
    logic [2:0]            w_rmod, w_wd;
    logic                  w_year_bad;
    logic                  w_load;

    function automatic logic [OSUM_W-1:0] octal_sum(input logic [DB-1:0] x);
        logic [XE_W-1:0]   xe;
        logic [OSUM_W-1:0] s;
        xe = XE_W'(x);
        s  = '0;
        for (int k = 0; k < DIG_N; k++) begin
            s = s + OSUM_W'(xe[3*k +: 3]);
        end
        return s;
    endfunction

    always_comb begin
        // step month and year in the walk direction
        if (r_neg) begin
            if (r_month == 4'd1) begin
                w_month_step = 4'd12;
                w_year_step  = r_year - YW'(1);
                w_y400_step  = (r_y400 == 9'd0) ? 9'd399 : r_y400 - 9'd1;
            end else begin
                w_month_step = r_month - 4'd1;
                w_year_step  = r_year;
                w_y400_step  = r_y400;
            end
        end else begin
            if (r_month == 4'd12) begin
                w_month_step = 4'd1;
                w_year_step  = r_year + YW'(1);
                w_y400_step  = (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
            end else begin
                w_month_step = r_month + 4'd1;
                w_year_step  = r_year;
                w_y400_step  = r_y400;
            end
        end
        // backward adds the length of the month entered, forward drops the current one
        w_len_month = r_neg ? w_month_step : r_month;
        w_len_y400  = r_neg ? w_y400_step : r_y400;
        w_len       = month_len(w_len_month, leap_of(w_len_y400));
        w_len_s     = $signed({{(DW-MLEN_W){1'b0}}, w_len});
        w_day_sum   = r_neg ? (r_day + w_len_s) : (r_day - w_len_s);
        if (r_neg) begin
            w_go = (r_year >= $signed(YW'(0))) && (r_day <= $signed(DW'(0)));
        end else begin
            w_go = (r_year <= $signed(YW'(YEAR_MAX))) && (r_day > w_len_s);
        end
    end

    // S_FOLD: digit sum and year quotient; S_RESID: fold to the residues
    always_comb begin
        w_osum  = octal_sum($unsigned(r_in.day_delta));
        w_yprod = YPROD_W'(r_in.start_year) * YPROD_W'(Y400_RECIP);
        w_osum2 = {1'b0, r_osum[2:0]} + {1'b0, r_osum[5:3]} + {3'b0, r_osum[6]};
        w_osum3 = {1'b0, w_osum2[2:0]} + {3'b0, w_osum2[3]};
        w_dmod  = (w_osum3 >= 4'd7) ? 3'(w_osum3 - 4'd7) : w_osum3[2:0];
        w_yq400 = YEAR_W'(r_yq) * YEAR_W'(YEAR_CYCLE);
        w_ymod  = r_in.start_year - w_yq400;
    end

    always_comb begin
        w_wd0  = (r_in.start_weekday == 3'd7) ? 3'd0 : r_in.start_weekday;
        w_radj = r_neg ? ({1'b0, r_drem} + SIGN_ADJ) : {1'b0, r_drem};
        w_rmod = (w_radj >= 4'd7) ? 3'(w_radj - 4'd7) : w_radj[2:0];
        w_wsum = {1'b0, w_wd0} + {1'b0, w_rmod};
        w_wd   = (w_wsum >= 4'd7) ? 3'(w_wsum - 4'd7) : w_wsum[2:0];
        w_year_bad = (r_year < $signed(YW'(0))) || (r_year > $signed(YW'(YEAR_MAX)));
    end

    assign w_load = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_status    = r_status;
        n_neg       = r_neg;
        n_osum      = r_osum;
        n_yq        = r_yq;
        n_drem      = r_drem;
        n_y400      = r_y400;
        n_year      = r_year;
        n_month     = r_month;
        n_day       = r_day;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_neg   = i_in_data.day_delta[DB-1];
                    n_year  = $signed({1'b0, i_in_data.start_year});
                    n_month = i_in_data.start_month;
                    n_day   = $signed({{(DW-DAY_W){1'b0}}, i_in_data.start_day})
                              + $signed({{2{i_in_data.day_delta[DB-1]}},
                                         i_in_data.day_delta});
                    if (i_in_data.day_delta == '0) begin
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else if (i_in_data.start_month < 4'd1 ||
                                 i_in_data.start_month > 4'd12) begin
                        n_status = ST_BAD_MONTH;
                        n_state  = S_DONE;
                    end else begin
                        n_status = ST_OK;
                        n_state  = S_FOLD;
                    end
                end
            end
            S_FOLD: begin
                n_osum  = w_osum;
                n_yq    = w_yprod[Y400_SHIFT +: YQ_W];
                n_state = S_RESID;
            end
            S_RESID: begin
                n_drem  = w_dmod;
                n_y400  = w_ymod[8:0];
                n_state = S_WALK;
            end
            S_WALK: begin
                if (w_go) begin
                    n_month = w_month_step;
                    n_year  = w_year_step;
                    n_y400  = w_y400_step;
                    // year fell below zero: stop without adding a length
                    if (!r_neg || w_year_step >= $signed(YW'(0))) begin
                        n_day = w_day_sum;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    if (r_status == ST_OK && !w_year_bad && r_in.day_delta != '0) begin
                        n_out.end_year    = r_year[YEAR_W-1:0];
                        n_out.end_month   = r_month;
                        n_out.end_day     = r_day[DAY_W-1:0];
                        n_out.end_weekday = w_wd;
                        n_out.status      = ST_OK;
                    end else begin
                        // echo the input date on zero offset or any error
                        n_out.end_year    = r_in.start_year;
                        n_out.end_month   = r_in.start_month;
                        n_out.end_day     = r_in.start_day;
                        n_out.end_weekday = r_in.start_weekday;
                        if (r_status == ST_OK && r_in.day_delta != '0) begin
                            n_out.status = ST_BAD_YEAR;
                        end else begin
                            n_out.status = r_status;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_status <= n_status;
        r_neg    <= n_neg;
        r_osum   <= n_osum;
        r_yq     <= n_yq;
        r_drem   <= n_drem;
        r_y400   <= n_y400;
        r_year   <= n_year;
        r_month  <= n_month;
        r_day    <= n_day;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
